// File: sv/usc_pkg.sv
// ============================================================================
// usc_pkg
// Types and constants shared by the update session controller modules.
// ============================================================================
package usc_pkg;

    // raw command codes as they arrive on the input channel
    localparam logic [3:0] CMD_TICK     = 4'd0;
    localparam logic [3:0] CMD_BEGIN    = 4'd1;
    localparam logic [3:0] CMD_CONFIRM  = 4'd2;
    localparam logic [3:0] CMD_DENY     = 4'd3;
    localparam logic [3:0] CMD_WRITE    = 4'd4;
    localparam logic [3:0] CMD_END      = 4'd5;
    localparam logic [3:0] CMD_ABORT    = 4'd6;
    localparam logic [3:0] CMD_LINKLOST = 4'd7;
    localparam logic [3:0] CMD_IDREJECT = 4'd8;

    // configuration register indexes
    localparam int          CFG_IDX_W    = 3;
    localparam int          CFG_DATA_W   = 32;
    localparam logic [2:0]  CFG_CAPACITY = 3'd0;
    localparam logic [2:0]  CFG_MIN_BATT = 3'd1;
    localparam logic [2:0]  CFG_CONF_TMO = 3'd2;
    localparam logic [2:0]  CFG_RECV_TMO = 3'd3;
    localparam logic [2:0]  CFG_PWR_EN   = 3'd4;

    // configuration reset values and field widths
    localparam int          CAP_W             = 24;
    localparam int          BATT_W            = 7;
    localparam int          TMO_W             = 32;
    localparam logic [23:0] CAP_RESET         = 24'hFF_FFFF;
    localparam logic [6:0]  BATT_RESET        = 7'd30;
    localparam logic [31:0] CONF_TMO_RESET    = 32'd60000;
    localparam logic [31:0] RECV_TMO_RESET    = 32'd10000;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_RECEIVE = 2'd2,
        PH_REBOOT  = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_BAD_IMAGE = 4'd1,
        ERR_TOO_LARGE = 4'd2,
        ERR_LOW_POWER = 4'd3,
        ERR_DENIED    = 4'd4,
        ERR_SEQ_GAP   = 4'd5,
        ERR_LINK_LOST = 4'd6,
        ERR_TIMEOUT   = 4'd7,
        ERR_TARGET    = 4'd8,
        ERR_PROJECT   = 4'd9
    } t_err;

    // classified operation; unused command codes become OP_IGNORE
    typedef enum logic [3:0] {
        OP_TICK     = 4'd0,
        OP_BEGIN    = 4'd1,
        OP_CONFIRM  = 4'd2,
        OP_DENY     = 4'd3,
        OP_WRITE    = 4'd4,
        OP_END      = 4'd5,
        OP_ABORT    = 4'd6,
        OP_LINKLOST = 4'd7,
        OP_IDREJECT = 4'd8,
        OP_IGNORE   = 4'd9
    } t_op;

    // phase-independent checks worked out by the front
    typedef struct packed {
        t_op  op;
        t_err begin_err;
        logic power_ok;
        logic backend_ok;
        logic project_matches;
        logic cnt_zero;
    } t_cls;

    // timeout settings handed to the back
    typedef struct packed {
        logic [31:0] confirm_ms;
        logic [31:0] receive_ms;
    } t_tmo;

endpackage

// File: sv/usc_ifs.sv
// ============================================================================
// usc interfaces
// Command, result and configuration channels of the update session controller.
// ============================================================================
interface usc_in_if #(
    parameter int SIZE_BITS = 24,
    parameter int TIME_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [3:0]           cmd;
    logic [TIME_BITS-1:0] now_ms;
    logic [SIZE_BITS-1:0] byte_count;
    logic [SIZE_BITS-1:0] chunk_offset;
    logic                 header_valid;
    logic                 power_valid;
    logic                 external_power;
    logic [6:0]           battery_percent;
    logic                 backend_ok;
    logic                 project_matches;

    modport source (
        output valid, cmd, now_ms, byte_count, chunk_offset, header_valid,
               power_valid, external_power, battery_percent, backend_ok,
               project_matches,
        input  ready
    );
    modport sink (
        input  valid, cmd, now_ms, byte_count, chunk_offset, header_valid,
               power_valid, external_power, battery_percent, backend_ok,
               project_matches,
        output ready
    );
endinterface

interface usc_out_if #(
    parameter int SIZE_BITS  = 24,
    parameter int COUNT_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic                  accepted;
    logic [1:0]            phase;
    logic [3:0]            error_code;
    logic [SIZE_BITS-1:0]  bytes_received;
    logic [SIZE_BITS-1:0]  image_bytes;
    logic [COUNT_BITS-1:0] failures;
    logic                  storage_abort;

    modport source (
        output valid, accepted, phase, error_code, bytes_received, image_bytes,
               failures, storage_abort,
        input  ready
    );
    modport sink (
        input  valid, accepted, phase, error_code, bytes_received, image_bytes,
               failures, storage_abort,
        output ready
    );
endinterface

interface usc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [usc_pkg::CFG_IDX_W-1:0]   index;
    logic [usc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/usc_front.sv
// ============================================================================
// usc_front
// Holds the configuration registers, takes command beats and classifies them
// (opcode decode, begin checks, power check) before they enter the queue.
// ============================================================================
module usc_front #(
    parameter int SIZE_BITS = 24,
    parameter int TIME_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    usc_in_if.sink        i_cmd,
    usc_cfg_if.sink       i_cfg,
    input  logic          i_push_ready,
    output logic          o_push_valid,
    output usc_pkg::t_cls o_cls,
    output usc_pkg::t_tmo o_tmo
);

    logic [SIZE_BITS-1:0]        r_cap;
    logic [usc_pkg::BATT_W-1:0]  r_batt;
    logic [usc_pkg::TMO_W-1:0]   r_conf_tmo;
    logic [usc_pkg::TMO_W-1:0]   r_recv_tmo;
    logic                        r_pwr_en;

    // configuration writes, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= SIZE_BITS'(usc_pkg::CAP_RESET);
            r_batt     <= usc_pkg::BATT_RESET;
            r_conf_tmo <= usc_pkg::CONF_TMO_RESET;
            r_recv_tmo <= usc_pkg::RECV_TMO_RESET;
            r_pwr_en   <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                usc_pkg::CFG_CAPACITY: r_cap <= SIZE_BITS'(i_cfg.data[usc_pkg::CAP_W-1:0]);
                usc_pkg::CFG_MIN_BATT: r_batt <= i_cfg.data[usc_pkg::BATT_W-1:0];
                usc_pkg::CFG_CONF_TMO: r_conf_tmo <= i_cfg.data[usc_pkg::TMO_W-1:0];
                usc_pkg::CFG_RECV_TMO: r_recv_tmo <= i_cfg.data[usc_pkg::TMO_W-1:0];
                usc_pkg::CFG_PWR_EN:   r_pwr_en <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign o_tmo.confirm_ms = r_conf_tmo;
    assign o_tmo.receive_ms = r_recv_tmo;

    // handshake passes straight to the queue
    assign o_push_valid = i_cmd.valid;
    assign i_cmd.ready  = i_push_ready;

    // opcode decode
    always_comb begin
        case (i_cmd.cmd)
            usc_pkg::CMD_TICK:     o_cls.op = usc_pkg::OP_TICK;
            usc_pkg::CMD_BEGIN:    o_cls.op = usc_pkg::OP_BEGIN;
            usc_pkg::CMD_CONFIRM:  o_cls.op = usc_pkg::OP_CONFIRM;
            usc_pkg::CMD_DENY:     o_cls.op = usc_pkg::OP_DENY;
            usc_pkg::CMD_WRITE:    o_cls.op = usc_pkg::OP_WRITE;
            usc_pkg::CMD_END:      o_cls.op = usc_pkg::OP_END;
            usc_pkg::CMD_ABORT:    o_cls.op = usc_pkg::OP_ABORT;
            usc_pkg::CMD_LINKLOST: o_cls.op = usc_pkg::OP_LINKLOST;
            usc_pkg::CMD_IDREJECT: o_cls.op = usc_pkg::OP_IDREJECT;
            default:               o_cls.op = usc_pkg::OP_IGNORE;
        endcase
    end

    // power source check
    assign o_cls.power_ok = !r_pwr_en ||
                            (i_cmd.power_valid &&
                             (i_cmd.external_power || (i_cmd.battery_percent >= r_batt)));

    assign o_cls.cnt_zero        = (i_cmd.byte_count == '0);
    assign o_cls.backend_ok      = i_cmd.backend_ok;
    assign o_cls.project_matches = i_cmd.project_matches;

    // begin checks in priority order: empty image or header, size limit, power
    always_comb begin
        if (o_cls.cnt_zero || !i_cmd.header_valid) begin
            o_cls.begin_err = usc_pkg::ERR_BAD_IMAGE;
        end else if (i_cmd.byte_count > r_cap) begin
            o_cls.begin_err = usc_pkg::ERR_TOO_LARGE;
        end else if (!o_cls.power_ok) begin
            o_cls.begin_err = usc_pkg::ERR_LOW_POWER;
        end else begin
            o_cls.begin_err = usc_pkg::ERR_NONE;
        end
    end

endmodule

// File: sv/usc_fifo.sv
// ============================================================================
// usc_fifo
// Short register queue that decouples the front from the back.
// ============================================================================
module usc_fifo #(
    parameter int WIDTH = 90
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_not_full,
    input  logic             i_pop,
    output logic             o_not_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = usc_pkg::QUEUE_PTR_W;
    localparam int CW = usc_pkg::QUEUE_CNT_W;

    logic [WIDTH-1:0] r_mem [usc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_not_full  = (r_count != CW'(usc_pkg::QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign wr_en       = i_push && o_not_full;
    assign rd_en       = i_pop && o_not_empty;
    assign o_data      = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PW'(usc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PW'(usc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: sv/usc_back.sv
// ============================================================================
// usc_back
// Session sequencer: carries out classified commands against the phase,
// offset, size, timestamps and failure count, and drives the result register.
// ============================================================================
module usc_back #(
    parameter int SIZE_BITS  = 24,
    parameter int TIME_BITS  = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_pop,
    input  usc_pkg::t_cls        i_cls,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic [SIZE_BITS-1:0] i_cnt,
    input  logic [SIZE_BITS-1:0] i_off,
    input  usc_pkg::t_tmo        i_tmo,
    usc_out_if.source            o_rsp
);

    localparam int TW = (TIME_BITS > usc_pkg::TMO_W) ? TIME_BITS : usc_pkg::TMO_W;

    usc_pkg::t_phase       r_phase, n_phase;
    usc_pkg::t_err         r_err, n_err;
    logic [SIZE_BITS-1:0]  r_offset, n_offset;
    logic [SIZE_BITS-1:0]  r_size, n_size;
    logic [COUNT_BITS-1:0] r_fail, n_fail;
    logic [TIME_BITS-1:0]  r_start, n_start;
    logic [TIME_BITS-1:0]  r_activity, n_activity;
    logic                  r_active, n_active;
    logic                  r_out_valid;
    logic                  r_acc, n_acc;
    logic                  r_abort, n_abort;

    logic                  rst_req;
    usc_pkg::t_err         rst_err;
    logic                  active_now;
    logic [TIME_BITS-1:0]  conf_age;
    logic [TIME_BITS-1:0]  recv_age;
    logic                  conf_expired;
    logic                  recv_expired;
    logic [SIZE_BITS-1:0]  room;

    // take the next command when the result slot is free or being drained
    assign o_pop = i_valid && (!r_out_valid || o_rsp.ready);

    // timeout and room checks
    assign conf_age     = i_now - r_start;
    assign recv_age     = i_now - r_activity;
    assign conf_expired = (i_now > r_start) &&
                          (TW'(conf_age) >= TW'(i_tmo.confirm_ms));
    assign recv_expired = (i_now > r_activity) &&
                          (TW'(recv_age) >= TW'(i_tmo.receive_ms));
    assign room         = (r_offset <= r_size) ? (r_size - r_offset) : '0;

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_err      = r_err;
        n_offset   = r_offset;
        n_size     = r_size;
        n_fail     = r_fail;
        n_start    = r_start;
        n_activity = r_activity;
        n_active   = r_active;
        n_acc      = 1'b0;
        n_abort    = 1'b0;
        rst_req    = 1'b0;
        rst_err    = usc_pkg::ERR_NONE;
        active_now = r_active;

        case (i_cls.op)
            usc_pkg::OP_TICK: begin
                if (r_phase == usc_pkg::PH_CONFIRM && conf_expired) begin
                    rst_req = 1'b1;
                    rst_err = usc_pkg::ERR_TIMEOUT;
                end else if (r_phase == usc_pkg::PH_RECEIVE && recv_expired) begin
                    rst_req = 1'b1;
                    rst_err = usc_pkg::ERR_LINK_LOST;
                end
            end
            usc_pkg::OP_BEGIN: begin
                if (r_phase == usc_pkg::PH_IDLE) begin
                    if (i_cls.begin_err != usc_pkg::ERR_NONE) begin
                        rst_req = 1'b1;
                        rst_err = i_cls.begin_err;
                    end else begin
                        n_phase    = usc_pkg::PH_CONFIRM;
                        n_err      = usc_pkg::ERR_NONE;
                        n_offset   = '0;
                        n_size     = i_cnt;
                        n_start    = i_now;
                        n_activity = i_now;
                        n_acc      = 1'b1;
                    end
                end
            end
            usc_pkg::OP_CONFIRM: begin
                if (r_phase == usc_pkg::PH_CONFIRM) begin
                    if (!i_cls.power_ok) begin
                        rst_req = 1'b1;
                        rst_err = usc_pkg::ERR_LOW_POWER;
                    end else if (!i_cls.backend_ok) begin
                        rst_req = 1'b1;
                        rst_err = usc_pkg::ERR_BAD_IMAGE;
                    end else begin
                        n_active   = 1'b1;
                        n_phase    = usc_pkg::PH_RECEIVE;
                        n_start    = i_now;
                        n_activity = i_now;
                        n_acc      = 1'b1;
                    end
                end
            end
            usc_pkg::OP_DENY: begin
                if (r_phase == usc_pkg::PH_CONFIRM) begin
                    rst_req = 1'b1;
                    rst_err = usc_pkg::ERR_DENIED;
                    n_acc   = 1'b1;
                end
            end
            usc_pkg::OP_WRITE: begin
                if (r_phase == usc_pkg::PH_RECEIVE && !i_cls.cnt_zero) begin
                    if (i_off != r_offset || i_cnt > room) begin
                        rst_req = 1'b1;
                        rst_err = usc_pkg::ERR_SEQ_GAP;
                    end else if (!i_cls.backend_ok) begin
                        rst_req = 1'b1;
                        rst_err = usc_pkg::ERR_BAD_IMAGE;
                    end else begin
                        n_offset   = r_offset + i_cnt;
                        n_activity = i_now;
                        n_acc      = 1'b1;
                    end
                end
            end
            usc_pkg::OP_END: begin
                if (r_phase == usc_pkg::PH_RECEIVE) begin
                    if (r_offset != r_size) begin
                        rst_req = 1'b1;
                        rst_err = usc_pkg::ERR_BAD_IMAGE;
                    end else begin
                        // backend is finished, not aborted
                        active_now = 1'b0;
                        n_active   = 1'b0;
                        if (!i_cls.backend_ok) begin
                            rst_req = 1'b1;
                            rst_err = usc_pkg::ERR_BAD_IMAGE;
                        end else begin
                            n_phase = usc_pkg::PH_REBOOT;
                            n_err   = usc_pkg::ERR_NONE;
                            n_acc   = 1'b1;
                        end
                    end
                end
            end
            usc_pkg::OP_ABORT: begin
                rst_req = 1'b1;
                rst_err = usc_pkg::ERR_NONE;
            end
            usc_pkg::OP_LINKLOST: begin
                if (r_phase == usc_pkg::PH_CONFIRM || r_phase == usc_pkg::PH_RECEIVE) begin
                    rst_req = 1'b1;
                    rst_err = usc_pkg::ERR_LINK_LOST;
                end
            end
            usc_pkg::OP_IDREJECT: begin
                if (r_phase == usc_pkg::PH_IDLE) begin
                    rst_req = 1'b1;
                    rst_err = i_cls.project_matches ? usc_pkg::ERR_TARGET
                                                    : usc_pkg::ERR_PROJECT;
                end
            end
            default: ;
        endcase

        // session reset
        if (rst_req) begin
            n_abort    = active_now;
            n_active   = 1'b0;
            n_phase    = usc_pkg::PH_IDLE;
            n_err      = rst_err;
            n_offset   = '0;
            n_size     = '0;
            n_start    = '0;
            n_activity = '0;
            if (rst_err != usc_pkg::ERR_NONE) begin
                n_fail = r_fail + COUNT_BITS'(1);
            end
        end
    end

    // session state, updated once per command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= usc_pkg::PH_IDLE;
            r_err      <= usc_pkg::ERR_NONE;
            r_offset   <= '0;
            r_size     <= '0;
            r_fail     <= '0;
            r_start    <= '0;
            r_activity <= '0;
            r_active   <= 1'b0;
        end else if (o_pop) begin
            r_phase    <= n_phase;
            r_err      <= n_err;
            r_offset   <= n_offset;
            r_size     <= n_size;
            r_fail     <= n_fail;
            r_start    <= n_start;
            r_activity <= n_activity;
            r_active   <= n_active;
        end
    end

    // result register; state fields show the state after the held command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_acc   <= n_acc;
            r_abort <= n_abort;
        end
    end

    // result beat
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.accepted       = r_acc;
    assign o_rsp.phase          = r_phase;
    assign o_rsp.error_code     = r_err;
    assign o_rsp.bytes_received = r_offset;
    assign o_rsp.image_bytes    = r_size;
    assign o_rsp.failures       = r_fail;
    assign o_rsp.storage_abort  = r_abort;

    // storage backend is only open while receiving
    a_active_in_receive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_phase == usc_pkg::PH_RECEIVE))
        else $error("storage active outside receiving phase");

    // idle phase carries no session
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == usc_pkg::PH_IDLE) |-> (r_offset == '0 && r_size == '0))
        else $error("idle phase with leftover offset or size");

    // offset never passes the announced size
    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset <= r_size)
        else $error("offset beyond image size");

    // failure count moves only together with an error
    a_fail_with_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_fail) |-> (r_err != usc_pkg::ERR_NONE))
        else $error("failure count changed without an error");

    // an abort beat always reports the idle phase
    a_abort_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_abort) |-> (r_phase == usc_pkg::PH_IDLE))
        else $error("storage abort outside idle phase");

endmodule

// File: sv/update_session_controller.sv
// ============================================================================
// update_session_controller
// Path: a command beat is written into the queue, the back takes it from the
// queue and its result beat is held in the result register until taken.
// Throughput: one command per cycle while the receiver takes results; the
// two-entry queue plus result register keep both sides stalling apart.
// Reset (synchronous, active low): phase idle, counters and times cleared,
// queue and result register empty, configuration at its default values.
// ============================================================================
module update_session_controller #(
    parameter int SIZE_BITS  = 24,
    parameter int TIME_BITS  = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    usc_in_if.sink    i_cmd,
    usc_cfg_if.sink   i_cfg,
    usc_out_if.source o_rsp
);

    localparam int CLS_W   = $bits(usc_pkg::t_cls);
    localparam int ENTRY_W = CLS_W + TIME_BITS + 2 * SIZE_BITS;

    usc_pkg::t_cls        front_cls;
    usc_pkg::t_cls        back_cls;
    usc_pkg::t_tmo        tmo;
    logic                 push_valid;
    logic                 push_ready;
    logic                 q_valid;
    logic                 pop;
    logic [ENTRY_W-1:0]   q_in;
    logic [ENTRY_W-1:0]   q_out;
    logic [TIME_BITS-1:0] q_now;
    logic [SIZE_BITS-1:0] q_cnt;
    logic [SIZE_BITS-1:0] q_off;

    // front: configuration and classification
    usc_front #(
        .SIZE_BITS (SIZE_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_cfg        (i_cfg),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_cls        (front_cls),
        .o_tmo        (tmo)
    );

    // queue entry packing
    assign q_in = {front_cls, i_cmd.now_ms, i_cmd.byte_count, i_cmd.chunk_offset};

    usc_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push_valid),
        .i_data      (q_in),
        .o_not_full  (push_ready),
        .i_pop       (pop),
        .o_not_empty (q_valid),
        .o_data      (q_out)
    );

    assign {back_cls, q_now, q_cnt, q_off} = q_out;

    // back: session sequencer and result register
    usc_back #(
        .SIZE_BITS  (SIZE_BITS),
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (pop),
        .i_cls   (back_cls),
        .i_now   (q_now),
        .i_cnt   (q_cnt),
        .i_off   (q_off),
        .i_tmo   (tmo),
        .o_rsp   (o_rsp)
    );

endmodule

// File: bench/update_session_controller_test.sv
// ============================================================================
// update_session_controller_test
// Self-checking bench for the firmware-update session sequencer. A directed
// pass walks each command but abort through some error and wrong-phase paths. Then four
// random passes run mostly well-formed update sessions with random faults and
// noise beats under different throttling and settings. A behavioral copy of
// the sequencer predicts each result beat, and a monitor checks every beat.
// ============================================================================
module update_session_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import usc_pkg::*;

    localparam int SIZE_W         = 24;
    localparam int TIME_W         = 32;
    localparam int COUNT_W        = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 250;

    // highest raw command code, not a defined command
    localparam logic [3:0] CMD_UNUSED_TOP = 4'd15;

    typedef struct packed {
        logic [3:0]        cmd;
        logic [TIME_W-1:0] now;
        logic [SIZE_W-1:0] count;
        logic [SIZE_W-1:0] offset;
        logic              hdr;
        logic              pwr_valid;
        logic              ext_pwr;
        logic [6:0]        batt;
        logic              backend_ok;
        logic              proj_match;
    } cmd_beat_t;

    typedef struct packed {
        logic               accepted;
        t_phase             phase;
        t_err               err;
        logic [SIZE_W-1:0]  rx_bytes;
        logic [SIZE_W-1:0]  img_bytes;
        logic [COUNT_W-1:0] fails;
        logic               storage_abort;
    } session_result_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    usc_in_if  cmd_if ();
    usc_out_if rsp_if ();
    usc_cfg_if cfg_if ();

    update_session_controller u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .i_cfg   (cfg_if),
        .o_rsp   (rsp_if)
    );

    // configuration copy
    logic [SIZE_W-1:0] cap_cfg       = CAP_RESET;
    logic [6:0]        batt_cfg      = BATT_RESET;
    logic [TIME_W-1:0] conf_tmo_cfg  = CONF_TMO_RESET;
    logic [TIME_W-1:0] recv_tmo_cfg  = RECV_TMO_RESET;
    logic              pwr_check_cfg = 1'b0;

    // session state copy
    t_phase             sess_phase   = PH_IDLE;
    t_err               sess_err     = ERR_NONE;
    logic [SIZE_W-1:0]  rx_offset    = '0;
    logic [SIZE_W-1:0]  img_size     = '0;
    logic [COUNT_W-1:0] fail_count   = '0;
    logic [TIME_W-1:0]  phase_t0     = '0;
    logic [TIME_W-1:0]  activity_t   = '0;
    logic               storage_busy = 1'b0;
    logic               abort_now    = 1'b0;

    session_result_t   pending_results[$];
    session_result_t   last_result    = '0;
    logic [TIME_W-1:0] clock_ms       = '0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                active_items   = 0;
    int                mismatch_count = 0;
    int                stall_cycles   = 0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // sequencer prediction
    // ------------------------------------------------------------------

    // session back to idle with an error code
    function automatic void end_session(t_err code);
        if (storage_busy) abort_now = 1'b1;
        storage_busy = 1'b0;
        sess_phase   = PH_IDLE;
        sess_err     = code;
        if (code != ERR_NONE) fail_count = fail_count + 1'b1;
        rx_offset  = '0;
        img_size   = '0;
        phase_t0   = '0;
        activity_t = '0;
    endfunction

    function automatic logic power_ok(cmd_beat_t b);
        if (!pwr_check_cfg) return 1'b1;
        if (!b.pwr_valid) return 1'b0;
        if (b.ext_pwr) return 1'b1;
        return b.batt >= batt_cfg;
    endfunction

    function automatic session_result_t step_session(cmd_beat_t b);
        session_result_t   r;
        logic              acc;
        logic [SIZE_W-1:0] room;
        acc       = 1'b0;
        abort_now = 1'b0;
        case (b.cmd)
            CMD_TICK: begin
                if (sess_phase == PH_CONFIRM && b.now > phase_t0 &&
                    b.now - phase_t0 >= conf_tmo_cfg)
                    end_session(ERR_TIMEOUT);
                else if (sess_phase == PH_RECEIVE && b.now > activity_t &&
                         b.now - activity_t >= recv_tmo_cfg)
                    end_session(ERR_LINK_LOST);
            end
            CMD_BEGIN: begin
                if (sess_phase == PH_IDLE) begin
                    if (b.count == 0 || !b.hdr) end_session(ERR_BAD_IMAGE);
                    else if (b.count > cap_cfg) end_session(ERR_TOO_LARGE);
                    else if (!power_ok(b)) end_session(ERR_LOW_POWER);
                    else begin
                        sess_phase = PH_CONFIRM;
                        sess_err   = ERR_NONE;
                        rx_offset  = '0;
                        img_size   = b.count;
                        phase_t0   = b.now;
                        activity_t = b.now;
                        acc        = 1'b1;
                    end
                end
            end
            CMD_CONFIRM: begin
                if (sess_phase == PH_CONFIRM) begin
                    if (!power_ok(b)) end_session(ERR_LOW_POWER);
                    else if (!b.backend_ok) end_session(ERR_BAD_IMAGE);
                    else begin
                        storage_busy = 1'b1;
                        sess_phase   = PH_RECEIVE;
                        phase_t0     = b.now;
                        activity_t   = b.now;
                        acc          = 1'b1;
                    end
                end
            end
            CMD_DENY: begin
                if (sess_phase == PH_CONFIRM) begin
                    end_session(ERR_DENIED);
                    acc = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (sess_phase == PH_RECEIVE && b.count != 0) begin
                    room = (rx_offset <= img_size) ? img_size - rx_offset : '0;
                    if (b.offset != rx_offset || b.count > room) end_session(ERR_SEQ_GAP);
                    else if (!b.backend_ok) end_session(ERR_BAD_IMAGE);
                    else begin
                        rx_offset  = rx_offset + b.count;
                        activity_t = b.now;
                        acc        = 1'b1;
                    end
                end
            end
            CMD_END: begin
                if (sess_phase == PH_RECEIVE) begin
                    if (rx_offset != img_size) end_session(ERR_BAD_IMAGE);
                    else begin
                        // backend is finished here, not aborted
                        storage_busy = 1'b0;
                        if (!b.backend_ok) end_session(ERR_BAD_IMAGE);
                        else begin
                            sess_phase = PH_REBOOT;
                            sess_err   = ERR_NONE;
                            acc        = 1'b1;
                        end
                    end
                end
            end
            CMD_ABORT: end_session(ERR_NONE);
            CMD_LINKLOST: begin
                if (sess_phase == PH_CONFIRM || sess_phase == PH_RECEIVE)
                    end_session(ERR_LINK_LOST);
            end
            CMD_IDREJECT: begin
                if (sess_phase == PH_IDLE)
                    end_session(b.proj_match ? ERR_TARGET : ERR_PROJECT);
            end
            default: ;
        endcase
        r.accepted      = acc;
        r.phase         = sess_phase;
        r.err           = sess_err;
        r.rx_bytes      = rx_offset;
        r.img_bytes     = img_size;
        r.fails         = fail_count;
        r.storage_abort = abort_now;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // beat builders
    // ------------------------------------------------------------------

    function automatic cmd_beat_t beat_of(logic [3:0] op, logic [SIZE_W-1:0] cnt,
                                          logic [SIZE_W-1:0] off, logic hdr,
                                          logic pv, logic ext, logic [6:0] batt,
                                          logic ok, logic proj);
        cmd_beat_t b;
        b.cmd        = op;
        b.now        = clock_ms;
        b.count      = cnt;
        b.offset     = off;
        b.hdr        = hdr;
        b.pwr_valid  = pv;
        b.ext_pwr    = ext;
        b.batt       = batt;
        b.backend_ok = ok;
        b.proj_match = proj;
        return b;
    endfunction

    // random content, time moves forward a little
    function automatic cmd_beat_t rand_beat(logic [3:0] op);
        clock_ms = clock_ms + $urandom_range(0, 20);
        return beat_of(op, SIZE_W'($urandom), SIZE_W'($urandom), 1'($urandom),
                       1'($urandom), 1'($urandom), 7'($urandom_range(0, 100)),
                       1'($urandom), 1'($urandom));
    endfunction

    // power reading that passes the check
    function automatic cmd_beat_t with_power(cmd_beat_t b);
        b.pwr_valid = 1'b1;
        b.ext_pwr   = 1'($urandom_range(0, 1));
        if (!b.ext_pwr) b.batt = 7'($urandom_range(batt_cfg, 100));
        return b;
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    task automatic send_beat(input cmd_beat_t b);
        session_result_t exp;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid           <= 1'b1;
        cmd_if.cmd             <= b.cmd;
        cmd_if.now_ms          <= b.now;
        cmd_if.byte_count      <= b.count;
        cmd_if.chunk_offset    <= b.offset;
        cmd_if.header_valid    <= b.hdr;
        cmd_if.power_valid     <= b.pwr_valid;
        cmd_if.external_power  <= b.ext_pwr;
        cmd_if.battery_percent <= b.batt;
        cmd_if.backend_ok      <= b.backend_ok;
        cmd_if.project_matches <= b.proj_match;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        exp = step_session(b);
        if (exp.accepted || exp != last_result) active_items++;
        last_result = exp;
        pending_results.push_back(exp);
    endtask

    // stop sending and let every result beat come back
    task automatic drain_results();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        case (idx)
            CFG_CAPACITY: cap_cfg       = val[SIZE_W-1:0];
            CFG_MIN_BATT: batt_cfg      = val[6:0];
            CFG_CONF_TMO: conf_tmo_cfg  = val;
            CFG_RECV_TMO: recv_tmo_cfg  = val;
            CFG_PWR_EN:   pwr_check_cfg = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic write_all_regs(input logic [SIZE_W-1:0] cap, input logic [6:0] batt,
                                  input logic [TIME_W-1:0] conf_tmo,
                                  input logic [TIME_W-1:0] recv_tmo, input logic pwr);
        drain_results();
        write_reg(CFG_CAPACITY, CFG_DATA_W'(cap));
        write_reg(CFG_MIN_BATT, CFG_DATA_W'(batt));
        write_reg(CFG_CONF_TMO, conf_tmo);
        write_reg(CFG_RECV_TMO, recv_tmo);
        write_reg(CFG_PWR_EN, CFG_DATA_W'(pwr));
    endtask

    // ------------------------------------------------------------------
    // random stimulus
    // ------------------------------------------------------------------

    // one update session, mostly clean, sometimes broken on the way
    task automatic run_session();
        cmd_beat_t         b;
        logic [SIZE_W-1:0] img_len;
        logic [SIZE_W-1:0] chunk;
        int                flaw;
        int                sel;
        flaw = $urandom_range(0, 99);
        if ($urandom_range(0, 29) == 0)
            img_len = $urandom_range(0, 1) ? '1 : SIZE_W'($urandom_range(1000, 24'hFF_FFFF));
        else
            img_len = SIZE_W'($urandom_range(1, 300));
        if (sess_phase != PH_IDLE) send_beat(rand_beat(CMD_ABORT));

        // announce the image
        b       = with_power(rand_beat(CMD_BEGIN));
        b.count = img_len;
        b.hdr   = 1'b1;
        if (flaw < 3) b.hdr = 1'b0;
        else if (flaw < 5) b.count = '0;
        else if (flaw < 8) b.pwr_valid = 1'b0;
        else if (flaw < 10) begin
            b.ext_pwr = 1'b0;
            b.batt    = 7'($urandom_range(0, batt_cfg));
        end
        send_beat(b);
        if (sess_phase == PH_CONFIRM && $urandom_range(0, 3) == 0) begin
            clock_ms = clock_ms + $urandom_range(0, 60);
            send_beat(rand_beat(CMD_TICK));
        end
        if (sess_phase != PH_CONFIRM) return;

        // user answer
        if (flaw >= 10 && flaw < 13) begin
            send_beat(rand_beat(CMD_DENY));
            return;
        end
        if (flaw >= 13 && flaw < 15) begin
            send_beat(rand_beat(CMD_LINKLOST));
            return;
        end
        b            = with_power(rand_beat(CMD_CONFIRM));
        b.backend_ok = !(flaw >= 15 && flaw < 18);
        send_beat(b);

        // chunks in order, with the odd fault or stray command
        while (sess_phase == PH_RECEIVE && rx_offset < img_size) begin
            sel = $urandom_range(0, 99);
            if (sel < 5) begin
                clock_ms = clock_ms + $urandom_range(0, 40);
                b = rand_beat(CMD_TICK);
            end else if (sel < 7) b = rand_beat(CMD_LINKLOST);
            else if (sel < 8) b = rand_beat(CMD_ABORT);
            else if (sel < 9) b = rand_beat(CMD_END);
            else begin
                chunk = img_size - rx_offset;
                if (img_size > 1000) begin
                    if ($urandom_range(0, 1)) chunk = SIZE_W'($urandom_range(1, chunk));
                end else if (chunk > 1) begin
                    chunk = SIZE_W'($urandom_range(1, (chunk > 64) ? 64 : chunk));
                end
                b            = rand_beat(CMD_WRITE);
                b.count      = chunk;
                b.offset     = rx_offset;
                b.backend_ok = 1'b1;
                if (sel < 11) b.offset = rx_offset + SIZE_W'($urandom_range(1, 3));
                else if (sel < 13)
                    b.count = img_size - rx_offset + SIZE_W'($urandom_range(1, 5));
                else if (sel < 14) b.backend_ok = 1'b0;
                else if (sel < 16) b.count = '0;
            end
            send_beat(b);
        end
        if (sess_phase != PH_RECEIVE) return;

        // final length and verification
        b            = rand_beat(CMD_END);
        b.backend_ok = ($urandom_range(0, 9) != 0);
        send_beat(b);

        // strays while rebooting, then leave with abort
        if (sess_phase == PH_REBOOT) begin
            repeat ($urandom_range(0, 2)) send_beat(rand_beat(4'($urandom_range(0, 15))));
            send_beat(rand_beat(CMD_ABORT));
        end
    endtask

    task automatic run_random_phase(input int send_pct, input int stall_pct,
                                    input logic [SIZE_W-1:0] cap, input logic [6:0] batt,
                                    input logic [TIME_W-1:0] conf_tmo,
                                    input logic [TIME_W-1:0] recv_tmo, input logic pwr);
        cmd_beat_t             b;
        int                    goal;
        int                    sel;
        int                    pick;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        write_all_regs(cap, batt, conf_tmo, recv_tmo, pwr);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        goal           = active_items + PHASE_ITEMS;
        while (active_items < goal) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                // noise burst, time may jump anywhere
                repeat ($urandom_range(2, 8)) begin
                    b = rand_beat(4'($urandom_range(0, 15)));
                    if ($urandom_range(0, 1)) begin
                        b.now    = $urandom;
                        clock_ms = b.now;
                    end
                    send_beat(b);
                end
            end else if (sel < 12) begin
                // hold off until the block has answered everything
                drain_results();
            end else if (sel < 20) begin
                // change one setting between sessions
                drain_results();
                idx  = CFG_IDX_W'($urandom_range(0, 4));
                pick = $urandom_range(0, 2);
                case (idx)
                    CFG_CAPACITY:
                        val = (pick == 0) ? '0 : (pick == 1) ? 32'hFF_FFFF : $urandom_range(1, 400);
                    CFG_MIN_BATT:
                        val = (pick == 0) ? '0 : (pick == 1) ? 32'd100 : $urandom_range(0, 100);
                    CFG_CONF_TMO, CFG_RECV_TMO:
                        val = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom_range(0, 80);
                    default:
                        val = $urandom_range(0, 1);
                endcase
                write_reg(idx, val);
            end else begin
                run_session();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // each command but abort through some of its error and wrong-phase paths
    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_all_regs(24'd1000, 7'd50, 32'd100, 32'd100, 1'b1);
        clock_ms = 32'd1000;
        // idle: ignored commands and identity rejects
        send_beat(beat_of(CMD_TICK, '0, '0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0));
        send_beat(beat_of(CMD_UNUSED_TOP, '1, '1, 1'b1, 1'b1, 1'b1, 7'd100, 1'b1, 1'b1));
        send_beat(beat_of(CMD_IDREJECT, '0, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b1));
        send_beat(beat_of(CMD_IDREJECT, '0, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        // begin refused: empty, bad header, too large, no reading, low battery
        send_beat(beat_of(CMD_BEGIN, '0, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        send_beat(beat_of(CMD_BEGIN, 24'd16, '0, 1'b0, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        send_beat(beat_of(CMD_BEGIN, 24'd1001, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        send_beat(beat_of(CMD_BEGIN, 24'd16, '0, 1'b1, 1'b0, 1'b1, 7'd100, 1'b1, 1'b0));
        send_beat(beat_of(CMD_BEGIN, 24'd16, '0, 1'b1, 1'b1, 1'b0, 7'd49, 1'b1, 1'b0));
        // battery exactly at the limit, then confirm timeout
        send_beat(beat_of(CMD_BEGIN, 24'd16, '0, 1'b1, 1'b1, 1'b0, 7'd50, 1'b1, 1'b0));
        send_beat(beat_of(CMD_WRITE, 24'd4, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        clock_ms = 32'd500;
        send_beat(beat_of(CMD_TICK, '0, '0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0));
        clock_ms = 32'd1100;
        send_beat(beat_of(CMD_TICK, '0, '0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0));
        // zero-length write, then overrun of the announced size
        clock_ms = 32'd2000;
        send_beat(beat_of(CMD_BEGIN, 24'd16, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        send_beat(beat_of(CMD_CONFIRM, '0, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        send_beat(beat_of(CMD_WRITE, '0, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        clock_ms = 32'd2050;
        send_beat(beat_of(CMD_WRITE, 24'd10, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        send_beat(beat_of(CMD_WRITE, 24'd7, 24'd10, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        // full image with failed verification
        clock_ms = 32'd3000;
        send_beat(beat_of(CMD_BEGIN, 24'd16, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        send_beat(beat_of(CMD_CONFIRM, '0, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        send_beat(beat_of(CMD_WRITE, 24'd16, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        send_beat(beat_of(CMD_END, '0, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b0, 1'b0));
        // deny near the top of the time range
        clock_ms = 32'hFFFF_FFF0;
        send_beat(beat_of(CMD_BEGIN, 24'd16, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        send_beat(beat_of(CMD_DENY, '0, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        send_beat(beat_of(CMD_LINKLOST, '0, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        // receive inactivity timeout with the backend open
        clock_ms = 32'd5000;
        send_beat(beat_of(CMD_BEGIN, 24'd16, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        send_beat(beat_of(CMD_CONFIRM, '0, '0, 1'b1, 1'b1, 1'b1, 7'd0, 1'b1, 1'b0));
        clock_ms = 32'd5100;
        send_beat(beat_of(CMD_TICK, '0, '0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0));
    endtask

    task automatic test_sessions_free_flow();
        run_random_phase(0, 0, 24'hFF_FFFF, 7'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_sessions_sender_gaps();
        run_random_phase(60, 0, 24'd2000, 7'd100, 32'd40, 32'd30, 1'b1);
    endtask

    task automatic test_sessions_receiver_stalls();
        run_random_phase(0, 60, 24'd300, 7'd30, 32'd0, 32'd0, 1'b1);
    endtask

    task automatic test_sessions_both_throttled();
        run_random_phase(38, 38, CAP_RESET, BATT_RESET, CONF_TMO_RESET, RECV_TMO_RESET, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        session_result_t exp;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result beat with nothing expected", $time);
            end else begin
                exp = pending_results.pop_front();
                if (rsp_if.accepted !== exp.accepted || rsp_if.phase !== exp.phase ||
                    rsp_if.error_code !== exp.err || rsp_if.bytes_received !== exp.rx_bytes ||
                    rsp_if.image_bytes !== exp.img_bytes || rsp_if.failures !== exp.fails ||
                    rsp_if.storage_abort !== exp.storage_abort) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: expected acc=%0b phase=%0d err=%0d rx=%0d img=%0d fails=%0d abort=%0b",
                                 $time, exp.accepted, exp.phase, exp.err, exp.rx_bytes,
                                 exp.img_bytes, exp.fails, exp.storage_abort);
                        $display("%0t: actual   acc=%0b phase=%0d err=%0d rx=%0d img=%0d fails=%0d abort=%0b",
                                 $time, rsp_if.accepted, rsp_if.phase, rsp_if.error_code,
                                 rsp_if.bytes_received, rsp_if.image_bytes, rsp_if.failures,
                                 rsp_if.storage_abort);
                    end
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
            (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        cmd_if.valid           = 1'b0;
        cmd_if.cmd             = CMD_TICK;
        cmd_if.now_ms          = '0;
        cmd_if.byte_count      = '0;
        cmd_if.chunk_offset    = '0;
        cmd_if.header_valid    = 1'b0;
        cmd_if.power_valid     = 1'b0;
        cmd_if.external_power  = 1'b0;
        cmd_if.battery_percent = '0;
        cmd_if.backend_ok      = 1'b0;
        cmd_if.project_matches = 1'b0;
        cfg_if.valid           = 1'b0;
        cfg_if.index           = CFG_CAPACITY;
        cfg_if.data            = '0;
        rsp_if.ready           = 1'b0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_sessions_free_flow();
        test_sessions_sender_gaps();
        test_sessions_receiver_stalls();
        test_sessions_both_throttled();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
sv/usc_pkg.sv
sv/usc_ifs.sv
sv/usc_front.sv
sv/usc_fifo.sv
sv/usc_back.sv
sv/update_session_controller.sv
bench/update_session_controller_test.sv
